// ===== design/adcts_pkg.sv =====
// ----------------------------------------------------------------------------
// adcts_pkg: shared types and constants for the ADC temp/supply sequencer
// Phase and control state encodings, divider status, register indexes.
// ----------------------------------------------------------------------------
`default_nettype none

package adcts_pkg;

	localparam int unsigned SampleW   = 10;
	localparam int unsigned CalW      = 16;
	localparam int unsigned CountW    = 8;
	localparam int unsigned ScaleSh   = 10;
	localparam int unsigned DividendW = CalW + ScaleSh;

	localparam logic [CalW-1:0]   CalReset    = 16'd1100;
	localparam logic [CountW-1:0] SettleReset = 8'd32;
	localparam logic [CalW-1:0]   SupplyMax   = 16'hFFFF;

	typedef enum logic {
		REG_VBG_CAL      = 1'b0,
		REG_SETTLE_COUNT = 1'b1
	} reg_idx_t;

	typedef enum logic [1:0] {
		PH_IDLE = 2'd0,
		PH_TEMP = 2'd1,
		PH_VBG  = 2'd2
	} phase_t;

	typedef enum logic [1:0] {
		CONV_NONE = 2'd0,
		CONV_TEMP = 2'd1,
		CONV_VBG  = 2'd2
	} conv_t;

	typedef enum logic {
		CS_READY = 1'b0,
		CS_DIV   = 1'b1
	} ctl_state_t;

	typedef struct packed {
		logic busy;
		logic done;
	} div_stat_t;

endpackage

`default_nettype wire

// ===== design/adc_temp_supply_sequencer.sv =====
// ----------------------------------------------------------------------------
// adc_temp_supply_sequencer: temperature/bandgap ADC burst sequencer
// Sequences temperature and bandgap bursts and calibrates the supply voltage.
// ----------------------------------------------------------------------------
// Usage: the input channel (in_valid/in_stall) carries requests: kind 0 is a
// start, kind 1 is a conversion-done event with its sample. Every request
// yields exactly one result on the output channel (out_valid/out_stall):
// the conversion to launch next, busy flag, stored temperature and supply.
// Most requests skip the divider: the result is registered at the accept
// edge and shows the next cycle, one request per cycle while in_stall is low.
// The last bandgap event of a burst runs the serial divider, one quotient
// bit per cycle; in_stall stays high until the divider signals done and
// its quotient is loaded into the supply store and the output register.
// The output register holds one result; while it is full and out_stall is
// high, in_stall is high and the result is held unchanged.
// Reset: phase idle, stores cleared, vbg_cal 1100, settle_count 32.
// Configuration via cfg_we/cfg_index/cfg_data: the user must write only while idle; the block does not enforce it.
// ----------------------------------------------------------------------------
`default_nettype none

module adc_temp_supply_sequencer (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          cfg_we,
	input  wire logic                          cfg_index,
	input  wire logic [adcts_pkg::CalW-1:0]    cfg_data,
	input  wire logic                          in_valid,
	output logic                               in_stall,
	input  wire logic                          kind,
	input  wire logic [adcts_pkg::SampleW-1:0] sample,
	output logic                               out_valid,
	input  wire logic                          out_stall,
	output logic      [1:0]                    start_conversion,
	output logic                               busy_res,
	output logic      [adcts_pkg::SampleW-1:0] temperature_raw,
	output logic      [adcts_pkg::CalW-1:0]    supply_value,
	output logic                               finished
);

	localparam int unsigned SW = adcts_pkg::SampleW;
	localparam int unsigned CW = adcts_pkg::CalW;
	localparam int unsigned NW = adcts_pkg::CountW;

	logic [CW-1:0] vbg_cal_q;
	logic [NW-1:0] settle_count_q;

	adcts_pkg::phase_t     phase_q, phase_n;
	adcts_pkg::ctl_state_t state_q, state_n;
	logic [NW-1:0]         remaining_q, remaining_n, rem_dec;
	logic [SW-1:0]         temp_q, temp_n;
	logic [CW-1:0]         supply_q, supply_n;
	adcts_pkg::conv_t      launch;
	logic                  calc;
	logic                  acc;
	logic                  div_start;

	logic                  out_valid_q;
	adcts_pkg::conv_t      out_conv_q;
	logic                  out_busy_q;
	logic [SW-1:0]         out_temp_q;
	logic [CW-1:0]         out_supply_q;
	logic                  out_fin_q;

	adcts_pkg::div_stat_t  div_stat;
	logic [CW-1:0]         quotient;

	adcts_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.cal      (vbg_cal_q),
		.raw      (sample),
		.stat     (div_stat),
		.quotient (quotient)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vbg_cal_q      <= adcts_pkg::CalReset;
			settle_count_q <= adcts_pkg::SettleReset;
		end else if (cfg_we) begin
			case (adcts_pkg::reg_idx_t'(cfg_index))
				adcts_pkg::REG_VBG_CAL:      vbg_cal_q      <= cfg_data;
				adcts_pkg::REG_SETTLE_COUNT: settle_count_q <= cfg_data[NW-1:0];
				default: ;
			endcase
		end
	end

	// request decode
	always_comb begin
		phase_n     = phase_q;
		remaining_n = remaining_q;
		temp_n      = temp_q;
		supply_n    = supply_q;
		launch      = adcts_pkg::CONV_NONE;
		calc        = 1'b0;
		rem_dec     = remaining_q - 1'b1;
		if (!kind) begin
			if (phase_q == adcts_pkg::PH_IDLE) begin
				phase_n     = adcts_pkg::PH_TEMP;
				remaining_n = settle_count_q;
				launch      = adcts_pkg::CONV_TEMP;
			end
		end else begin
			case (phase_q)
				adcts_pkg::PH_TEMP: begin
					temp_n      = sample;
					remaining_n = rem_dec;
					if (rem_dec != '0) begin
						launch = adcts_pkg::CONV_TEMP;
					end else begin
						phase_n     = adcts_pkg::PH_VBG;
						remaining_n = settle_count_q;
						launch      = adcts_pkg::CONV_VBG;
					end
				end
				adcts_pkg::PH_VBG: begin
					supply_n    = {{(CW-SW){1'b0}}, sample};
					remaining_n = rem_dec;
					if (rem_dec != '0) begin
						launch = adcts_pkg::CONV_VBG;
					end else begin
						phase_n = adcts_pkg::PH_IDLE;
						calc    = 1'b1;
					end
				end
				default: ;
			endcase
		end
	end

	always_comb begin
		state_n = state_q;
		case (state_q)
			adcts_pkg::CS_READY: if (acc && calc) state_n = adcts_pkg::CS_DIV;
			adcts_pkg::CS_DIV:   if (div_stat.done) state_n = adcts_pkg::CS_READY;
			default:             state_n = adcts_pkg::CS_READY;
		endcase
	end

	always_comb begin
		in_stall  = (state_q != adcts_pkg::CS_READY) || (out_valid_q && out_stall);
		acc       = in_valid && !in_stall;
		div_start = acc && calc;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= adcts_pkg::CS_READY;
			phase_q     <= adcts_pkg::PH_IDLE;
			remaining_q <= '0;
			temp_q      <= '0;
			supply_q    <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_n;
			if (acc) begin
				phase_q     <= phase_n;
				remaining_q <= remaining_n;
				temp_q      <= temp_n;
				supply_q    <= supply_n;
			end else if (div_stat.done) begin
				supply_q <= quotient;
			end
			if ((acc && !calc) || div_stat.done) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (acc && !calc) begin
			out_conv_q   <= launch;
			out_busy_q   <= phase_n != adcts_pkg::PH_IDLE;
			out_temp_q   <= temp_n;
			out_supply_q <= supply_n;
			out_fin_q    <= 1'b0;
		end else if (div_stat.done) begin
			out_conv_q   <= adcts_pkg::CONV_NONE;
			out_busy_q   <= 1'b0;
			out_temp_q   <= temp_q;
			out_supply_q <= quotient;
			out_fin_q    <= 1'b1;
		end
	end

	always_comb begin
		out_valid        = out_valid_q;
		start_conversion = out_conv_q;
		busy_res         = out_busy_q;
		temperature_raw  = out_temp_q;
		supply_value     = out_supply_q;
		finished         = out_fin_q;
	end

endmodule

`default_nettype wire

// ===== design/adcts_div.sv =====
// ----------------------------------------------------------------------------
// adcts_div: serial restoring divider for the supply calibration
// Computes (cal << 10) / raw one quotient bit per cycle, saturated to 16 bits.
// ----------------------------------------------------------------------------
`default_nettype none

module adcts_div (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          start,
	input  wire logic [adcts_pkg::CalW-1:0]    cal,
	input  wire logic [adcts_pkg::SampleW-1:0] raw,
	output adcts_pkg::div_stat_t               stat,
	output logic      [adcts_pkg::CalW-1:0]    quotient
);

	localparam int unsigned DW   = adcts_pkg::DividendW;
	localparam int unsigned SW   = adcts_pkg::SampleW;
	localparam int unsigned CntW = $clog2(DW + 1);

	logic [SW-1:0]   rem_q;
	logic [DW-1:0]   quo_q;
	logic [SW-1:0]   divisor_q;
	logic [CntW-1:0] cnt_q;
	logic            busy_q;
	logic            done_q;

	logic [SW:0]     shifted;
	logic [SW:0]     diff;
	logic            ge;
	logic [SW-1:0]   rem_next;

	always_comb begin
		shifted  = {rem_q, quo_q[DW-1]};
		diff     = shifted - {1'b0, divisor_q};
		ge       = shifted >= {1'b0, divisor_q};
		rem_next = ge ? diff[SW-1:0] : shifted[SW-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= !start && busy_q && (cnt_q == CntW'(1));
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CntW'(DW);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CntW'(1)) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q     <= '0;
			quo_q     <= {cal, {adcts_pkg::ScaleSh{1'b0}}};
			divisor_q <= raw;
		end else if (busy_q) begin
			rem_q <= rem_next;
			quo_q <= {quo_q[DW-2:0], ge};
		end
	end

	// zero divisor or quotient past 16 bits clamps to full scale
	always_comb begin
		if (divisor_q == '0 || |quo_q[DW-1:adcts_pkg::CalW]) begin
			quotient = adcts_pkg::SupplyMax;
		end else begin
			quotient = quo_q[adcts_pkg::CalW-1:0];
		end
		stat.busy = busy_q;
		stat.done = done_q;
	end

endmodule

`default_nettype wire
